@@ rtl/core/wzhit_pkg.sv @@
// ----------------------------------------------------------------------------
// wzhit_pkg
// Shared types and constants for the window z-order hit table.
// ----------------------------------------------------------------------------
`default_nettype none

package wzhit_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int SLOT_W      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int COUNT_W     = $clog2(MAX_WINDOWS + 1);

    localparam int OP_W        = 3;
    localparam int REF_W       = 4;
    localparam int POS_W       = 13;
    localparam int SIZE_W      = 12;
    localparam int OUT_REF_W   = 4;
    localparam int OUT_COUNT_W = 5;
    localparam int EXT_W       = POS_W + 2;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_RAISE  = 3'd2,
        OP_HIT    = 3'd3,
        OP_MOVE   = 3'd4,
        OP_NOP    = 3'd7
    } op_t;

    typedef struct packed {
        slot_t                   slot;
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] top;
        logic [SIZE_W-1:0]       width;
        logic [SIZE_W-1:0]       height;
    } win_t;

    typedef struct packed {
        op_t                     op;
        slot_t                   target;
        slot_t                   new_slot;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SIZE_W-1:0]       size_w;
        logic [SIZE_W-1:0]       size_h;
    } cmd_t;

    typedef struct packed {
        logic  tok;
        logic  found;
        win_t  carry;
        logic  placed;
        logic  hit;
        slot_t hit_slot;
    } link_t;

endpackage

`default_nettype wire

@@ rtl/core/wzhit_cell.sv @@
// ----------------------------------------------------------------------------
// wzhit_cell
// One z-order position: holds a window entry and acts on the command token
// as it passes, then hands the token on to the next position.
// ----------------------------------------------------------------------------
`default_nettype none

module wzhit_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire wzhit_pkg::cmd_t     cmd,
    input  wire wzhit_pkg::link_t    link_in,
    input  wire logic                next_valid,
    input  wire wzhit_pkg::win_t     next_win,
    output wzhit_pkg::link_t         link_out,
    output logic                     cell_valid,
    output wzhit_pkg::win_t          cell_win
);
    import wzhit_pkg::*;

    logic  valid_reg, valid_next;
    win_t  win_reg, win_next;
    link_t link_reg, link_next;

    logic              self_match;
    logic              found;
    win_t              carry;
    logic              covered;
    logic signed [EXT_W-1:0] left_ext, top_ext, right_ext, bottom_ext, px_ext, py_ext;

    assign self_match = valid_reg && (win_reg.slot == cmd.target);
    assign found      = link_in.found || self_match;
    assign carry      = self_match ? win_reg : link_in.carry;

    assign left_ext   = EXT_W'(win_reg.left);
    assign top_ext    = EXT_W'(win_reg.top);
    assign right_ext  = left_ext + $signed(EXT_W'(win_reg.width));
    assign bottom_ext = top_ext + $signed(EXT_W'(win_reg.height));
    assign px_ext     = EXT_W'(cmd.pos_x);
    assign py_ext     = EXT_W'(cmd.pos_y);
    assign covered    = (px_ext >= left_ext) && (px_ext <= right_ext) &&
                        (py_ext >= top_ext) && (py_ext <= bottom_ext);

    always_comb begin
        valid_next = valid_reg;
        win_next   = win_reg;
        link_next  = link_in;
        if (link_in.tok) begin
            case (cmd.op)
                OP_ADD: begin
                    if (!link_in.placed && !valid_reg) begin
                        valid_next       = 1'b1;
                        win_next.slot    = cmd.new_slot;
                        win_next.left    = cmd.pos_x;
                        win_next.top     = cmd.pos_y;
                        win_next.width   = cmd.size_w;
                        win_next.height  = cmd.size_h;
                        link_next.placed = 1'b1;
                    end
                end
                OP_REMOVE, OP_RAISE: begin
                    link_next.found = found;
                    link_next.carry = carry;
                    if (found && valid_reg) begin
                        if (next_valid) begin
                            win_next = next_win;
                        end else if (cmd.op == OP_RAISE) begin
                            win_next = carry;
                        end else begin
                            valid_next = 1'b0;
                        end
                    end
                end
                OP_MOVE: begin
                    if (self_match) begin
                        win_next.left = cmd.pos_x;
                        win_next.top  = cmd.pos_y;
                    end
                end
                OP_HIT: begin
                    if (valid_reg && covered) begin
                        link_next.hit      = 1'b1;
                        link_next.hit_slot = win_reg.slot;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            link_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            link_reg  <= link_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign link_out   = link_reg;
    assign cell_valid = valid_reg;
    assign cell_win   = win_reg;

endmodule

`default_nettype wire

@@ rtl/core/wzhit_chain.sv @@
// ----------------------------------------------------------------------------
// wzhit_chain
// Row of z-order cells, back to front; the command token ripples one cell
// per cycle and leaves the front cell with the hit-test answer.
// ----------------------------------------------------------------------------
`default_nettype none

module wzhit_chain (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire wzhit_pkg::cmd_t                    cmd,
    input  wire wzhit_pkg::link_t                   link_in,
    output wzhit_pkg::link_t                        link_out,
    output logic [wzhit_pkg::MAX_WINDOWS-1:0]       valid_vec
);
    import wzhit_pkg::*;

    link_t links [MAX_WINDOWS+1];
    win_t  wins  [MAX_WINDOWS];
    logic  nvalid [MAX_WINDOWS];
    win_t  nwin   [MAX_WINDOWS];

    assign links[0] = link_in;

    for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
        if (i < MAX_WINDOWS - 1) begin : g_mid
            assign nvalid[i] = valid_vec[i+1];
            assign nwin[i]   = wins[i+1];
        end else begin : g_last
            assign nvalid[i] = 1'b0;
            assign nwin[i]   = '0;
        end

        wzhit_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .link_in    (links[i]),
            .next_valid (nvalid[i]),
            .next_win   (nwin[i]),
            .link_out   (links[i+1]),
            .cell_valid (valid_vec[i]),
            .cell_win   (wins[i])
        );
    end

    assign link_out = links[MAX_WINDOWS];

endmodule

`default_nettype wire

@@ rtl/core/window_z_order_hit_table_top.sv @@
// ----------------------------------------------------------------------------
// window_z_order_hit_table_top
// Window slot table with back-to-front z-order, focus and point hit test.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | operation, window_ref, pos_x/y, size_w/h
//  m_      | out | m_valid / m_ready  | status, result_ref, window_count, focus
//
//  Between acceptance and result the command token ripples through the
//  cell row one z position per cycle.
//  One transaction is in flight at a time; s_ready is high while idle.
//  A finished result waits in the output register while the next one runs.
//  Reset (aresetn low, synchronous) empties the table and drops focus.
// ----------------------------------------------------------------------------
`default_nettype none

module window_z_order_hit_table_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [wzhit_pkg::OP_W-1:0]            s_operation,
    input  wire logic [wzhit_pkg::REF_W-1:0]           s_window_ref,
    input  wire logic signed [wzhit_pkg::POS_W-1:0]    s_pos_x,
    input  wire logic signed [wzhit_pkg::POS_W-1:0]    s_pos_y,
    input  wire logic [wzhit_pkg::SIZE_W-1:0]          s_size_w,
    input  wire logic [wzhit_pkg::SIZE_W-1:0]          s_size_h,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_status,
    output logic [wzhit_pkg::OUT_REF_W-1:0]            m_result_ref,
    output logic [wzhit_pkg::OUT_COUNT_W-1:0]          m_window_count,
    output logic                                       m_focus_valid,
    output logic [wzhit_pkg::OUT_REF_W-1:0]            m_focus_ref
);
    import wzhit_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [MAX_WINDOWS-1:0]   used_reg, used_next;
    logic [COUNT_W-1:0]       live_reg, live_next;
    logic                     focus_reg, focus_next;
    slot_t                    focus_slot_reg, focus_slot_next;
    logic                     start_reg, start_next;
    logic                     fail_reg, fail_next;
    cmd_t                     cmd_reg, cmd_next;
    logic                     res_status_reg, res_status_next;
    slot_t                    res_slot_reg, res_slot_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_status_reg, m_status_next;
    logic [OUT_REF_W-1:0]     m_ref_reg, m_ref_next;
    logic [OUT_COUNT_W-1:0]   m_count_reg, m_count_next;
    logic                     m_fvalid_reg, m_fvalid_next;
    logic [OUT_REF_W-1:0]     m_fref_reg, m_fref_next;

    logic                     accept;
    logic                     load_out;
    slot_t                    ref_slot;
    logic                     ref_live;
    logic [MAX_WINDOWS-1:0]   free_onehot;
    slot_t                    free_slot;
    link_t                    link_head, link_tail;
    logic [MAX_WINDOWS-1:0]   cell_valid;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign ref_slot = SLOT_W'(s_window_ref);
    assign ref_live = (32'(s_window_ref) < 32'(MAX_WINDOWS)) && used_reg[ref_slot];

    assign free_onehot = ~used_reg & (used_reg + MAX_WINDOWS'(1));

    always_comb begin
        free_slot = '0;
        for (int i = 0; i < MAX_WINDOWS; i++) begin
            if (free_onehot[i]) begin
                free_slot = free_slot | SLOT_W'(i);
            end
        end
    end

    always_comb begin
        used_next       = used_reg;
        live_next       = live_reg;
        focus_next      = focus_reg;
        focus_slot_next = focus_slot_reg;
        cmd_next        = cmd_reg;
        fail_next       = fail_reg;
        if (accept) begin
            cmd_next.target   = ref_slot;
            cmd_next.new_slot = free_slot;
            cmd_next.pos_x    = s_pos_x;
            cmd_next.pos_y    = s_pos_y;
            cmd_next.size_w   = s_size_w;
            cmd_next.size_h   = s_size_h;
            cmd_next.op       = OP_NOP;
            fail_next         = 1'b1;
            case (s_operation)
                OP_ADD: begin
                    if (live_reg < COUNT_W'(MAX_WINDOWS)) begin
                        used_next[free_slot] = 1'b1;
                        live_next            = live_reg + COUNT_W'(1);
                        if (!focus_reg) begin
                            focus_next      = 1'b1;
                            focus_slot_next = free_slot;
                        end
                        cmd_next.op = OP_ADD;
                        fail_next   = 1'b0;
                    end
                end
                OP_REMOVE: begin
                    if (ref_live) begin
                        used_next[ref_slot] = 1'b0;
                        live_next           = live_reg - COUNT_W'(1);
                        if (focus_reg && (focus_slot_reg == ref_slot)) begin
                            focus_next      = 1'b0;
                            focus_slot_next = '0;
                        end
                        cmd_next.op = OP_REMOVE;
                        fail_next   = 1'b0;
                    end
                end
                OP_RAISE: begin
                    if (ref_live) begin
                        focus_next      = 1'b1;
                        focus_slot_next = ref_slot;
                        cmd_next.op     = OP_RAISE;
                        fail_next       = 1'b0;
                    end
                end
                OP_HIT: begin
                    cmd_next.op = OP_HIT;
                end
                OP_MOVE: begin
                    if (ref_live) begin
                        cmd_next.op = OP_MOVE;
                        fail_next   = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        link_head     = '0;
        link_head.tok = start_reg;
    end

    assign start_next = accept;

    wzhit_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd_reg),
        .link_in   (link_head),
        .link_out  (link_tail),
        .valid_vec (cell_valid)
    );

    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (link_tail.tok) begin
                    state_next = ST_DONE;
                    if (cmd_reg.op == OP_HIT) begin
                        res_status_next = !link_tail.hit;
                        res_slot_next   = link_tail.hit ? link_tail.hit_slot : '0;
                    end else if (cmd_reg.op == OP_ADD) begin
                        res_status_next = fail_reg;
                        res_slot_next   = cmd_reg.new_slot;
                    end else begin
                        res_status_next = fail_reg;
                        res_slot_next   = '0;
                    end
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_ref_next    = m_ref_reg;
        m_count_next  = m_count_reg;
        m_fvalid_next = m_fvalid_reg;
        m_fref_next   = m_fref_reg;
        if (load_out) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_ref_next    = OUT_REF_W'(res_slot_reg);
            m_count_next  = OUT_COUNT_W'(live_reg);
            m_fvalid_next = focus_reg;
            m_fref_next   = OUT_REF_W'(focus_slot_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            live_reg       <= '0;
            focus_reg      <= 1'b0;
            focus_slot_reg <= '0;
            start_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            live_reg       <= live_next;
            focus_reg      <= focus_next;
            focus_slot_reg <= focus_slot_next;
            start_reg      <= start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        fail_reg       <= fail_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_ref_reg      <= m_ref_next;
        m_count_reg    <= m_count_next;
        m_fvalid_reg   <= m_fvalid_next;
        m_fref_reg     <= m_fref_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_ref   = m_ref_reg;
    assign m_window_count = m_count_reg;
    assign m_focus_valid  = m_fvalid_reg;
    assign m_focus_ref    = m_fref_reg;

`ifndef ASSERT_OFF
    a_live_matches_used: assert property (@(posedge aclk) disable iff (!aresetn)
        32'($countones(used_reg)) == 32'(live_reg))
        else $error("live count differs from occupied slots");

    a_focus_on_used: assert property (@(posedge aclk) disable iff (!aresetn)
        focus_reg |-> used_reg[focus_slot_reg])
        else $error("focus held by a free slot");

    a_cells_match_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (32'($countones(cell_valid)) == 32'(live_reg)))
        else $error("z row length differs from live count");

    a_tail_only_running: assert property (@(posedge aclk) disable iff (!aresetn)
        link_tail.tok |-> (state_reg == ST_RUN))
        else $error("token left the row outside a run");
`endif

endmodule

`default_nettype wire
